/* rtl/core/dbe_pkg.sv */
// Shared constants, register codes and lane types of the debounce and rotary block.
`default_nettype none

package dbe_pkg;

   localparam int NumLanes = 8;
   localparam int LaneW = 3;
   localparam int LevelW = 8;
   localparam int CountW = 8;
   localparam int LockW = 8;
   localparam int ClickW = 16;
   localparam int IncW = 2;
   localparam int CsrIdxW = 8;
   localparam int CsrDataW = 16;

   localparam int DefaultNumInputs = 8;
   localparam int DefaultFirstChannel = 0;

   localparam logic [LevelW-1:0] EnableReset = 8'hFF;
   localparam logic [LevelW-1:0] StableReset = 8'hFF;
   localparam logic [LevelW-1:0] PendingReset = 8'hFF;
   localparam logic [LockW-1:0] LockTicksReset = 8'd20;
   localparam logic [ClickW-1:0] ClickTicksReset = 16'd500;

   typedef enum logic [CsrIdxW-1:0] {
      RegInputEnable = 8'd0,
      RegRisingEdge  = 8'd1,
      RegFallingEdge = 8'd2,
      RegRotary      = 8'd3,
      RegLockTicks   = 8'd4,
      RegClickTicks  = 8'd5
   } csr_reg_type;

   typedef struct packed {
      logic tick;
      logic active;
      logic sample;
      logic stable;
      logic pending;
      logic enable;
   } lane_ctrl_type;

   typedef struct packed {
      logic              changed;
      logic              accepted;
      logic [CountW-1:0] count;
   } lane_status_type;

endpackage

`default_nettype wire

/* rtl/core/dbe_lane.sv */
// One input lane: change detection, lockout timer, click timer and click counter.
`default_nettype none

module dbe_lane (
   input  logic                         clock,
   input  logic                         reset,
   input  dbe_pkg::lane_ctrl_type       ctrl_i,
   input  logic [dbe_pkg::LockW-1:0]    lock_ticks,
   input  logic [dbe_pkg::ClickW-1:0]   click_ticks,
   input  logic [dbe_pkg::IncW-1:0]     fire_count,
   output dbe_pkg::lane_status_type     status_o
);
   import dbe_pkg::*;

   logic [LockW-1:0]  lock_ff, lock_in, lock_pre;
   logic [ClickW-1:0] click_ff, click_in, click_pre;
   logic [CountW-1:0] count_ff, count_in, count_pre;
   logic              changed, accepted;

   always_comb begin
      changed = ctrl_i.active && ctrl_i.enable && (ctrl_i.sample != ctrl_i.stable)
                && (lock_ff == '0);
      accepted = changed && ctrl_i.pending;

      lock_pre = (accepted && (lock_ticks != '0)) ? lock_ticks : lock_ff;
      click_pre = (fire_count != '0) ? click_ticks : click_ff;
      count_pre = count_ff + CountW'(fire_count);

      lock_in = lock_ff;
      click_in = click_ff;
      count_in = count_ff;
      if (ctrl_i.tick) begin
         lock_in = lock_pre;
         click_in = click_pre;
         count_in = count_pre;
         if (ctrl_i.active && (lock_pre != '0)) begin
            lock_in = lock_pre - 1'b1;
         end
         if (ctrl_i.active && (click_pre != '0)) begin
            click_in = click_pre - 1'b1;
            if (click_in == '0) begin
               count_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_ff <= '0;
         click_ff <= '0;
         count_ff <= '0;
      end else begin
         lock_ff <= lock_in;
         click_ff <= click_in;
         count_ff <= count_in;
      end
   end

   assign status_o = '{changed: changed, accepted: accepted, count: count_ff};

endmodule

`default_nettype wire

/* rtl/core/dbe_merge.sv */
// Merging stage: turns the accepted bits of all lanes into ordered triggers and counts.
`default_nettype none

module dbe_merge #(
   parameter int FIRST_CHANNEL = dbe_pkg::DefaultFirstChannel
) (
   input  logic [dbe_pkg::NumLanes-1:0] accepted_i,
   input  logic [dbe_pkg::LevelW-1:0]   stable_i,
   input  logic [dbe_pkg::LevelW-1:0]   sample_i,
   input  logic [dbe_pkg::LevelW-1:0]   rotary_mask,
   input  logic [dbe_pkg::LevelW-1:0]   rising_edge_mask,
   input  logic [dbe_pkg::LevelW-1:0]   falling_edge_mask,
   input  logic [dbe_pkg::CountW-1:0]   counts_i [dbe_pkg::NumLanes],
   output logic [dbe_pkg::NumLanes-1:0] fire_o,
   output logic [dbe_pkg::LaneW-1:0]    chan_o   [dbe_pkg::NumLanes],
   output logic [dbe_pkg::CountW-1:0]   count_o  [dbe_pkg::NumLanes],
   output logic [dbe_pkg::IncW-1:0]     inc_o    [dbe_pkg::NumLanes]
);
   import dbe_pkg::*;

   logic [LevelW-1:0] new_levels;
   logic [LaneW-1:0]  target [NumLanes];
   logic              own    [NumLanes];
   logic              pair_lo [NumLanes];
   logic              pair_hi [NumLanes];
   logic              prior  [NumLanes];

   always_comb begin
      new_levels = stable_i ^ accepted_i;
      for (int b = 0; b < NumLanes; b++) begin
         pair_lo[b] = new_levels[2 * (b / 2)];
         pair_hi[b] = (b % 2 == 1) ? new_levels[2 * (b / 2) + 1] : stable_i[2 * (b / 2) + 1];
         if (rotary_mask[b]) begin
            fire_o[b] = accepted_i[b] && !pair_lo[b] && !pair_hi[b];
            target[b] = LaneW'(2 * (b / 2)) | {{(LaneW-1){1'b0}}, stable_i[2 * (b / 2)]};
         end else begin
            fire_o[b] = accepted_i[b] && ((sample_i[b] && rising_edge_mask[b])
                        || (!sample_i[b] && falling_edge_mask[b]));
            target[b] = LaneW'(b);
         end
         own[b] = (target[b] == LaneW'(b));
      end

      for (int b = 0; b < NumLanes; b++) begin
         if (b % 2 == 1) begin
            prior[b] = fire_o[b - 1] && (target[b - 1] == target[b]);
         end else begin
            prior[b] = 1'b0;
         end
         count_o[b] = (own[b] ? counts_i[b] : counts_i[b ^ 1])
                      + CountW'(prior[b]) + CountW'(1);
         chan_o[b] = target[b] + LaneW'(FIRST_CHANNEL);
         inc_o[b] = IncW'(fire_o[b] && own[b])
                    + IncW'(fire_o[b ^ 1] && (target[b ^ 1] == LaneW'(b)));
      end
   end

endmodule

`default_nettype wire

/* rtl/core/dbe_emit.sv */
// Trigger buffer of one tick and the result output register.
`default_nettype none

module dbe_emit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load_i,
   input  logic [dbe_pkg::NumLanes-1:0] fire_i,
   input  logic [dbe_pkg::LaneW-1:0]    chan_i  [dbe_pkg::NumLanes],
   input  logic [dbe_pkg::CountW-1:0]   count_i [dbe_pkg::NumLanes],
   input  logic [dbe_pkg::LevelW-1:0]   stable_i,
   output logic                         ready_o,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [dbe_pkg::LaneW-1:0]    rsp_channel,
   output logic [dbe_pkg::CountW-1:0]   rsp_click_count,
   output logic [dbe_pkg::LevelW-1:0]   rsp_stable_levels,
   output logic                         rsp_last
);
   import dbe_pkg::*;

   logic [NumLanes-1:0] rem_ff, rem_in, rem_after;
   logic [LaneW-1:0]    chan_ff [NumLanes];
   logic [CountW-1:0]   count_ff [NumLanes];
   logic [LevelW-1:0]   stable_ff;
   logic                valid_ff;
   logic [LaneW-1:0]    channel_ff;
   logic [CountW-1:0]   click_ff;
   logic [LevelW-1:0]   levels_ff;
   logic                last_ff;
   logic                out_free, take;
   logic [LaneW-1:0]    sel;

   always_comb begin
      out_free = !valid_ff || !rsp_stall;
      take = out_free && (rem_ff != '0);
      sel = '0;
      for (int b = NumLanes - 1; b >= 0; b--) begin
         if (rem_ff[b]) begin
            sel = LaneW'(b);
         end
      end
      rem_after = rem_ff;
      if (take) begin
         rem_after[sel] = 1'b0;
      end
      ready_o = (rem_after == '0);
      rem_in = load_i ? fire_i : rem_after;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         rem_ff <= rem_in;
         if (take) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_i) begin
         chan_ff <= chan_i;
         count_ff <= count_i;
         stable_ff <= stable_i;
      end
      if (take) begin
         channel_ff <= chan_ff[sel];
         click_ff <= count_ff[sel];
         levels_ff <= stable_ff;
         last_ff <= (rem_after == '0);
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_channel = channel_ff;
   assign rsp_click_count = click_ff;
   assign rsp_stable_levels = levels_ff;
   assign rsp_last = last_ff;

endmodule

`default_nettype wire

/* rtl/core/input_debounce_edge_rotary_top.sv */
// Top level of the debounced input port with lockout, edge triggers and rotary decoding.
// Results of a tick pass through the trigger buffer and then the output register.
// Throughput: results leave one per cycle while rsp_stall does not hold the output register;
// a tick holds the trigger buffer until its last result moves out, and the next tick is taken
// in that same cycle; a tick that raises no trigger does not hold the buffer.
// Reset: synchronous; settings, control state, lane timers and output valid; not the payload.
`default_nettype none

module input_debounce_edge_rotary_top #(
   parameter int NUM_INPUTS    = dbe_pkg::DefaultNumInputs,
   parameter int FIRST_CHANNEL = dbe_pkg::DefaultFirstChannel
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [dbe_pkg::LevelW-1:0]     req_port_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [dbe_pkg::LaneW-1:0]      rsp_channel,
   output logic [dbe_pkg::CountW-1:0]     rsp_click_count,
   output logic [dbe_pkg::LevelW-1:0]     rsp_stable_levels,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [dbe_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [dbe_pkg::CsrDataW-1:0]   csr_data
);
   import dbe_pkg::*;

   logic [LevelW-1:0] enable_ff, enable_in;
   logic [LevelW-1:0] rise_ff, rise_in;
   logic [LevelW-1:0] fall_ff, fall_in;
   logic [LevelW-1:0] rotary_ff, rotary_in;
   logic [LockW-1:0]  lock_ticks_ff, lock_ticks_in;
   logic [ClickW-1:0] click_ticks_ff, click_ticks_in;
   logic [LevelW-1:0] stable_ff, stable_in;
   logic [LevelW-1:0] pending_ff, pending_in;

   logic                tick;
   logic                emit_ready;
   lane_ctrl_type       lane_ctrl [NumLanes];
   lane_status_type     lane_status [NumLanes];
   logic [NumLanes-1:0] changed, accepted, fire;
   logic [CountW-1:0]   lane_count [NumLanes];
   logic [LaneW-1:0]    chan [NumLanes];
   logic [CountW-1:0]   count [NumLanes];
   logic [IncW-1:0]     inc [NumLanes];

   assign csr_ready = 1'b1;
   assign req_stall = !emit_ready;
   assign tick = req_valid && emit_ready;

   always_comb begin
      enable_in = enable_ff;
      rise_in = rise_ff;
      fall_in = fall_ff;
      rotary_in = rotary_ff;
      lock_ticks_in = lock_ticks_ff;
      click_ticks_in = click_ticks_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_reg_type'(csr_index))
            RegInputEnable: enable_in = csr_data[LevelW-1:0];
            RegRisingEdge:  rise_in = csr_data[LevelW-1:0];
            RegFallingEdge: fall_in = csr_data[LevelW-1:0];
            RegRotary:      rotary_in = csr_data[LevelW-1:0];
            RegLockTicks:   lock_ticks_in = csr_data[LockW-1:0];
            RegClickTicks:  click_ticks_in = csr_data[ClickW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int g = 0; g < NumLanes; g++) begin
         lane_ctrl[g] = '{tick: tick, active: (g < NUM_INPUTS), sample: req_port_sample[g],
                          stable: stable_ff[g], pending: pending_ff[g], enable: enable_ff[g]};
         changed[g] = lane_status[g].changed;
         accepted[g] = lane_status[g].accepted;
         lane_count[g] = lane_status[g].count;
      end
      stable_in = stable_ff;
      pending_in = pending_ff;
      if (tick) begin
         stable_in = stable_ff ^ accepted;
         pending_in = changed & ~accepted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= EnableReset;
         rise_ff <= '0;
         fall_ff <= '0;
         rotary_ff <= '0;
         lock_ticks_ff <= LockTicksReset;
         click_ticks_ff <= ClickTicksReset;
         stable_ff <= StableReset;
         pending_ff <= PendingReset;
      end else begin
         enable_ff <= enable_in;
         rise_ff <= rise_in;
         fall_ff <= fall_in;
         rotary_ff <= rotary_in;
         lock_ticks_ff <= lock_ticks_in;
         click_ticks_ff <= click_ticks_in;
         stable_ff <= stable_in;
         pending_ff <= pending_in;
      end
   end

   for (genvar g = 0; g < NumLanes; g++) begin : g_lane
      dbe_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .ctrl_i      (lane_ctrl[g]),
         .lock_ticks  (lock_ticks_ff),
         .click_ticks (click_ticks_ff),
         .fire_count  (inc[g]),
         .status_o    (lane_status[g])
      );
   end

   dbe_merge #(
      .FIRST_CHANNEL (FIRST_CHANNEL)
   ) u_merge (
      .accepted_i        (accepted),
      .stable_i          (stable_ff),
      .sample_i          (req_port_sample),
      .rotary_mask       (rotary_ff),
      .rising_edge_mask  (rise_ff),
      .falling_edge_mask (fall_ff),
      .counts_i          (lane_count),
      .fire_o            (fire),
      .chan_o            (chan),
      .count_o           (count),
      .inc_o             (inc)
   );

   dbe_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .load_i            (tick),
      .fire_i            (fire),
      .chan_i            (chan),
      .count_i           (count),
      .stable_i          (stable_in),
      .ready_o           (emit_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_channel       (rsp_channel),
      .rsp_click_count   (rsp_click_count),
      .rsp_stable_levels (rsp_stable_levels),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

/* rtl/core/dbe_checker.sv */
// Port-level checks of the result channel and their attachment to the top level.
`default_nettype none

module dbe_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [dbe_pkg::LaneW-1:0]    rsp_channel,
   input wire logic [dbe_pkg::CountW-1:0]   rsp_click_count,
   input wire logic [dbe_pkg::LevelW-1:0]   rsp_stable_levels,
   input wire logic                         rsp_last
);

   // A stalled result beat stays offered.
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // A stalled result beat keeps its payload.
   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_channel) && $stable(rsp_click_count)
         && $stable(rsp_stable_levels) && $stable(rsp_last))
      else $error("result payload changed while stalled");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // The results of one tick leave without gaps.
   a_tick_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("gap inside the results of one tick");

   // All results of one tick report the same debounced levels.
   a_tick_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_stable_levels == $past(rsp_stable_levels))
      else $error("debounced levels changed inside one tick");

endmodule

bind input_debounce_edge_rotary_top dbe_checker u_dbe_checker (.*);

`default_nettype wire

/* tb/tb_input_debounce_edge_rotary_top.sv */
// Self-checking testbench for the debounced input port: directed, back-pressure and random runs.
`timescale 1ns / 1ps

module tb_input_debounce_edge_rotary_top;
   import dbe_pkg::*;

   localparam int NumInputs = DefaultNumInputs;
   localparam int FirstChannel = DefaultFirstChannel;
   localparam int StuckLimit = 2000;
   localparam int SettleCycles = 8;
   localparam int HoldOffCycles = 200;
   localparam logic [CsrIdxW-1:0] RegUnmapped = 8'd6;

   typedef struct {
      logic [LaneW-1:0]  channel;
      logic [CountW-1:0] count;
      logic [LevelW-1:0] levels;
      logic              is_last;
   } trigger_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [LevelW-1:0] req_port_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [LaneW-1:0] rsp_channel;
   logic [CountW-1:0] rsp_click_count;
   logic [LevelW-1:0] rsp_stable_levels;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [CsrDataW-1:0] csr_data = '0;

   // Register copies and debounce state of the predictor.
   logic [LevelW-1:0] en_mask, rise_mask, fall_mask, rot_mask;
   logic [LockW-1:0]  lock_len;
   logic [ClickW-1:0] click_len;
   logic [LevelW-1:0] stable_lv, pending_lv, locked_lv;
   logic [LockW-1:0]  lock_tmr [8];
   logic [ClickW-1:0] click_tmr [8];
   logic [CountW-1:0] click_cnt [8];

   trigger_type expected_triggers[$];
   trigger_type want;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   int stuck_cycles = 0;
   int errors = 0;
   int ticks_sent = 0;
   int triggers_checked = 0;
   int reg_writes = 0;

   input_debounce_edge_rotary_top u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_port_sample(req_port_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_channel(rsp_channel),
      .rsp_click_count(rsp_click_count),
      .rsp_stable_levels(rsp_stable_levels),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] exp_val);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, exp_val, $realtime);
      errors++;
   endtask

   task automatic clear_debounce_state();
      en_mask = EnableReset;
      rise_mask = '0;
      fall_mask = '0;
      rot_mask = '0;
      lock_len = LockTicksReset;
      click_len = ClickTicksReset;
      stable_lv = StableReset;
      pending_lv = PendingReset;
      locked_lv = '0;
      for (int b = 0; b < 8; b++) begin
         lock_tmr[b] = '0;
         click_tmr[b] = '0;
         click_cnt[b] = '0;
      end
   endtask

   task automatic debounce_tick(input logic [LevelW-1:0] sample);
      logic [LevelW-1:0] old_lv, work, next_pend, changes;
      logic [LaneW-1:0] ch_list[$];
      logic [CountW-1:0] cnt_list[$];
      trigger_type t;
      int even, tgt;
      old_lv = stable_lv;
      work = stable_lv;
      next_pend = '0;
      changes = (old_lv ^ sample) & en_mask & ~locked_lv;
      for (int b = 0; b < NumInputs; b++) begin
         if (!changes[b]) continue;
         if (!pending_lv[b]) begin
            next_pend[b] = 1'b1;
            continue;
         end
         work[b] = ~work[b];
         if (lock_len != 0) begin
            locked_lv[b] = 1'b1;
            lock_tmr[b] = lock_len;
         end
         tgt = -1;
         if (rot_mask[b]) begin
            even = b & 6;
            if (work[even +: 2] == 2'b00) tgt = old_lv[even] ? even + 1 : even;
         end else if ((sample[b] && rise_mask[b]) || (!sample[b] && fall_mask[b])) begin
            tgt = b;
         end
         if (tgt >= 0) begin
            tgt = tgt & 7;
            click_cnt[tgt] = click_cnt[tgt] + 8'd1;
            click_tmr[tgt] = click_len;
            ch_list.push_back(3'((FirstChannel + tgt) & 7));
            cnt_list.push_back(click_cnt[tgt]);
         end
      end
      stable_lv = work;
      pending_lv = next_pend;
      for (int b = 0; b < NumInputs; b++) begin
         if (lock_tmr[b] > 0) begin
            lock_tmr[b]--;
            if (lock_tmr[b] == 0) locked_lv[b] = 1'b0;
         end
         if (click_tmr[b] > 0) begin
            click_tmr[b]--;
            if (click_tmr[b] == 0) click_cnt[b] = '0;
         end
      end
      for (int k = 0; k < ch_list.size(); k++) begin
         t.channel = ch_list[k];
         t.count = cnt_list[k];
         t.levels = stable_lv;
         t.is_last = (k == ch_list.size() - 1);
         expected_triggers.push_back(t);
      end
   endtask

   task automatic send_tick(input logic [LevelW-1:0] sample);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
         req_port_sample = 8'($urandom);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_port_sample = sample;
      do @(posedge clock); while (req_stall);
      debounce_tick(sample);
      ticks_sent++;
   endtask

   task automatic send_held(input logic [LevelW-1:0] sample, input int n_ticks);
      for (int k = 0; k < n_ticks; k++) send_tick(sample);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_triggers.size() != 0) @(posedge clock);
   endtask

   task automatic settle();
      wait_drained();
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         RegInputEnable: en_mask = data[7:0];
         RegRisingEdge:  rise_mask = data[7:0];
         RegFallingEdge: fall_mask = data[7:0];
         RegRotary:      rot_mask = data[7:0];
         RegLockTicks:   lock_len = data[7:0];
         RegClickTicks:  click_len = data;
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_all(input logic [7:0] en, input logic [7:0] rise, input logic [7:0] fall,
                            input logic [7:0] rot, input logic [7:0] lock,
                            input logic [15:0] click);
      write_reg(RegInputEnable, {8'h00, en});
      write_reg(RegRisingEdge, {8'h00, rise});
      write_reg(RegFallingEdge, {8'h00, fall});
      write_reg(RegRotary, {8'h00, rot});
      write_reg(RegLockTicks, {8'h00, lock});
      write_reg(RegClickTicks, click);
   endtask

   function automatic logic [LevelW-1:0] next_target(input logic [LevelW-1:0] cur);
      logic [LevelW-1:0] nxt;
      logic [1:0] p, bin;
      nxt = cur;
      for (int k = 0; k < 4; k++) begin
         p = cur[2*k +: 2];
         if (rot_mask[2*k] || rot_mask[2*k+1]) begin
            if ($urandom_range(1) == 1) begin
               bin = {p[1], p[1] ^ p[0]};
               bin = ($urandom_range(1) == 1) ? bin + 2'd1 : bin - 2'd1;
               nxt[2*k +: 2] = {bin[1], bin[1] ^ bin[0]};
            end
         end else begin
            nxt[2*k +: 2] = p ^ 2'($urandom_range(3));
         end
      end
      return nxt;
   endfunction

   // Mostly held levels and quadrature steps, with some single-tick glitches.
   task automatic random_ticks(input int n_ticks);
      logic [LevelW-1:0] target;
      int sent, hold;
      target = stable_lv;
      sent = 0;
      while (sent < n_ticks) begin
         if ($urandom_range(99) < 15) begin
            send_tick(target ^ 8'($urandom));
            sent++;
         end else begin
            target = next_target(target);
            hold = $urandom_range(1, 4);
            send_held(target, hold);
            sent += hold;
         end
      end
   endtask

   task automatic test_first_change_and_lock();
      write_reg(RegFallingEdge, 16'h00FF);
      write_reg(RegRisingEdge, 16'h000F);
      write_reg(RegLockTicks, 16'h0003);
      send_tick(8'h00);
      send_held(8'hFF, 4);
      settle();
   endtask

   task automatic test_zero_settings();
      write_reg(RegUnmapped, 16'h1234);
      write_reg(RegInputEnable, 16'h0000);
      write_reg(RegLockTicks, 16'h0000);
      write_reg(RegClickTicks, 16'h0000);
      write_reg(RegRisingEdge, 16'hABF0);
      send_tick(8'h00);
      settle();
      write_reg(RegInputEnable, 16'h00F0);
      send_held(8'h00, 3);
      send_held(8'hFF, 2);
      settle();
   endtask

   task automatic test_click_clear();
      write_reg(RegInputEnable, 16'h00FF);
      write_reg(RegLockTicks, 16'h0001);
      write_reg(RegClickTicks, 16'h0002);
      send_held(8'h00, 4);
      send_held(8'hFF, 2);
      settle();
   endtask

   task automatic test_rotary();
      write_all(8'hFF, 8'h00, 8'h00, 8'hFF, 8'd1, 16'd0);
      send_held(8'hAA, 2);
      send_held(8'h00, 2);
      send_held(8'h55, 2);
      send_held(8'h00, 2);
      send_held(8'hFF, 2);
      send_held(8'h00, 2);
      settle();
   endtask

   task automatic test_click_counting();
      logic [LevelW-1:0] level;
      write_all(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'd1, 16'd0);
      level = stable_lv;
      for (int k = 0; k < 10; k++) begin
         level = ~level;
         send_held(level, 2);
      end
      settle();
   endtask

   task automatic test_backpressure();
      logic [LevelW-1:0] level;
      write_all(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'd1, 16'd300);
      level = stable_lv;
      hold_request = HoldOffCycles;
      for (int k = 0; k < 20; k++) begin
         level = ~level;
         send_held(level, 2);
      end
      settle();
   endtask

   task automatic test_random_phase(input int send_pct, input int stall_p, input logic [7:0] en,
                                    input logic [7:0] rise, input logic [7:0] fall,
                                    input logic [7:0] rot, input logic [7:0] lock,
                                    input logic [15:0] click, input int n_ticks);
      write_all(en, rise, fall, rot, lock, click);
      send_idle_pct = send_pct;
      stall_pct = stall_p;
      random_ticks(n_ticks / 2);
      wait_drained();
      random_ticks(n_ticks - n_ticks / 2);
      settle();
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_triggers.size() == 0) begin
            report_mismatch("unexpected trigger on channel", 16'(rsp_channel), 16'd0);
         end else begin
            want = expected_triggers.pop_front();
            if (rsp_channel !== want.channel)
               report_mismatch("channel", 16'(rsp_channel), 16'(want.channel));
            if (rsp_click_count !== want.count)
               report_mismatch("click_count", 16'(rsp_click_count), 16'(want.count));
            if (rsp_stable_levels !== want.levels)
               report_mismatch("stable_levels", 16'(rsp_stable_levels), 16'(want.levels));
            if (rsp_last !== want.is_last)
               report_mismatch("last", 16'(rsp_last), 16'(want.is_last));
            triggers_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= StuckLimit) begin
            $display("Timeout: no beat moved for %0d cycles.", StuckLimit);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      clear_debounce_state();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_first_change_and_lock();
      test_zero_settings();
      test_click_clear();
      test_rotary();
      test_click_counting();
      test_backpressure();
      test_random_phase(0, 0, 8'hFF, 8'($urandom), 8'($urandom), 8'h00, 8'd1, 16'd1, 50);
      test_random_phase(61, 0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom_range(1, 4)), 16'($urandom_range(1, 30)), 50);
      test_random_phase(0, 61, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'd2, 16'hFFFF, 50);
      test_random_phase(20, 20, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom_range(1, 3)), 16'($urandom_range(1, 100)), 50);
      test_random_phase(0, 0, 8'hFF, 8'hFF, 8'h00, 8'h0F, 8'd255, 16'd40, 20);

      $display("Covered %0d ticks, %0d triggers and %0d register writes.",
               ticks_sent, triggers_checked, reg_writes);
      $display("Runs: edges, lockout, zero settings, click clearing, rotary, counting, stalls.");
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* input_debounce_edge_rotary_top.f */
rtl/core/dbe_pkg.sv
rtl/core/dbe_lane.sv
rtl/core/dbe_merge.sv
rtl/core/dbe_emit.sv
rtl/core/input_debounce_edge_rotary_top.sv
rtl/core/dbe_checker.sv
tb/tb_input_debounce_edge_rotary_top.sv
